// ----- rtl/cidl_pkg.sv -----
// ----------------------------------------------------------------------------
// cidl_pkg
// Shared types and constants of the cubic interpolated delay line: payload
// structs, sample and fraction widths, and controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package cidl_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS      = 24;
   localparam int FRACTION_BITS    = 16;
   localparam int DISTANCE_BITS    = 32;
   localparam int RING_LENGTH_BITS = 17;

   // storage defaults
   localparam int RING_DEPTH_DEFAULT = 65536;
   localparam int MIN_RING           = 8;

   localparam logic [RING_LENGTH_BITS-1:0] RING_LENGTH_RESET = RING_LENGTH_BITS'(48004);

   // input transaction
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_write;
      logic signed [SAMPLE_BITS-1:0] right_write;
      logic [DISTANCE_BITS-1:0]      delay_distance;
   } cidl_req_type;

   // result transaction
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_read;
      logic signed [SAMPLE_BITS-1:0] right_read;
   } cidl_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_write;
      logic load;
      logic position;
      logic prev;
      logic read;
      logic shift;
      logic coef;
      logic write;
      logic mul;
      logic add;
      logic out_load;
   } cidl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic hist_ok;
   } cidl_status_type;

endpackage

// ----- rtl/cidl_datapath.sv -----
// ----------------------------------------------------------------------------
// cidl_datapath
// Ring memories, pointers, read position arithmetic and the two Horner
// multiply/add lanes of the cubic interpolated delay line.
// ----------------------------------------------------------------------------
module cidl_datapath #(
   parameter int RING_DEPTH = cidl_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  cidl_pkg::cidl_req_type                    req_payload,
   input  logic                                      csr_write_enable,
   input  logic [cidl_pkg::RING_LENGTH_BITS-1:0]     csr_write_data,
   input  cidl_pkg::cidl_cmd_type                    cmd,
   output cidl_pkg::cidl_status_type                 status,
   output cidl_pkg::cidl_rsp_type                    rsp_payload
);

   localparam int S      = cidl_pkg::SAMPLE_BITS;
   localparam int F      = cidl_pkg::FRACTION_BITS;
   localparam int DW     = cidl_pkg::DISTANCE_BITS;
   localparam int RLW    = cidl_pkg::RING_LENGTH_BITS;
   localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int LEN_W  = $clog2(RING_DEPTH + 1);
   localparam int CMP_W  = (LEN_W > RLW) ? LEN_W : RLW;
   localparam int PW     = (((LEN_W + F) > (DW + 1)) ? (LEN_W + F) : (DW + 1)) + 1;
   localparam int ACC_W  = S + 8;
   localparam int PROD_W = ACC_W + F + 1;

   localparam logic [DW-1:0]              DIST_ONE = DW'(1) << F;
   localparam logic signed [PROD_W-1:0]   HALF     = PROD_W'(1) << (F - 1);
   localparam logic signed [ACC_W-1:0]    ACC_ONE  = ACC_W'(1);
   localparam logic signed [ACC_W-1:0]    SAT_MAX  = (ACC_W'(1) << (S - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0]    SAT_MIN  = ~SAT_MAX;

   // ring memories
   logic signed [S-1:0] ring_left  [RING_DEPTH];
   logic signed [S-1:0] ring_right [RING_DEPTH];

   // control registers
   logic [RLW-1:0]    ring_len_ff, ring_len_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [LEN_W-1:0]  filled_ff, filled_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // per-transaction registers
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [ADDR_W-1:0]   wpe_ff, wpe_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [DW-1:0]       dist_ff, dist_in;
   logic signed [S-1:0] smp_ff [2];
   logic signed [S-1:0] smp_in [2];
   logic [F-1:0]        frac_ff, frac_in;
   logic                hist_ok_ff, hist_ok_in;

   // memory read data
   logic signed [S-1:0] rd_ff [2];

   // interpolation lanes
   logic signed [S-1:0]      y_ff    [2][4];
   logic signed [S-1:0]      y_in    [2][4];
   logic signed [ACC_W-1:0]  acc_ff  [2];
   logic signed [ACC_W-1:0]  acc_in  [2];
   logic signed [PROD_W-1:0] prod_ff [2];
   logic signed [PROD_W-1:0] prod_in [2];
   logic signed [ACC_W-1:0]  a2_ff   [2];
   logic signed [ACC_W-1:0]  a2_in   [2];
   logic signed [ACC_W-1:0]  a1_ff   [2];
   logic signed [ACC_W-1:0]  a1_in   [2];
   logic signed [ACC_W-1:0]  a0_ff   [2];
   logic signed [ACC_W-1:0]  a0_in   [2];
   cidl_pkg::cidl_rsp_type   rsp_ff, rsp_in;

   // combinational helpers
   logic [CMP_W-1:0]         len_raw;
   logic [LEN_W-1:0]         len_clamp;
   logic [PW-1:0]            wp_pos, dist_x, need_x, have_x, diff_x, pos_x;
   logic                     hist_ok;
   logic [ADDR_W-1:0]        addr_dec, addr_inc, wp_next;
   logic                     ring_we;
   logic [ADDR_W-1:0]        ring_wa;
   logic signed [S-1:0]      ring_wd [2];
   logic signed [ACC_W-1:0]  yx [2][4];
   logic signed [PROD_W-1:0] rnd [2];
   logic signed [ACC_W-1:0]  half_v [2];
   logic signed [ACC_W-1:0]  sat_v [2];
   logic signed [S-1:0]      out_v [2];

   // effective ring length
   always_comb begin
      len_raw = CMP_W'(ring_len_ff);
      if (len_raw < CMP_W'(cidl_pkg::MIN_RING)) begin
         len_clamp = LEN_W'(cidl_pkg::MIN_RING);
      end else if (len_raw > CMP_W'(RING_DEPTH)) begin
         len_clamp = LEN_W'(RING_DEPTH);
      end else begin
         len_clamp = LEN_W'(len_raw);
      end
   end

   // read position and history check
   always_comb begin
      wp_pos  = PW'(wpe_ff) << F;
      dist_x  = PW'(dist_ff);
      need_x  = dist_x + PW'(DIST_ONE);
      have_x  = PW'(fill_ff) << F;
      hist_ok = (need_x <= have_x);
      diff_x  = wp_pos - dist_x;
      pos_x   = (dist_x > wp_pos) ? (diff_x + (PW'(len_ff) << F)) : diff_x;
   end

   // pointer stepping with wrap at the ring length
   always_comb begin
      addr_dec = (addr_ff == '0) ? ADDR_W'(len_ff - LEN_W'(1)) : (addr_ff - ADDR_W'(1));
      addr_inc = ((LEN_W'(addr_ff) + LEN_W'(1)) == len_ff) ? '0 : (addr_ff + ADDR_W'(1));
      wp_next  = ((LEN_W'(wpe_ff) + LEN_W'(1)) == len_ff) ? '0 : (wpe_ff + ADDR_W'(1));
   end

   // memory write port
   always_comb begin
      ring_we = cmd.clear_write | cmd.write;
      ring_wa = cmd.clear_write ? addr_ff : wpe_ff;
      for (int c = 0; c < 2; c++) begin
         ring_wd[c] = cmd.clear_write ? '0 : smp_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_left[ring_wa]  <= ring_wd[0];
         ring_right[ring_wa] <= ring_wd[1];
      end
      if (cmd.read) begin
         rd_ff[0] <= ring_left[addr_ff];
         rd_ff[1] <= ring_right[addr_ff];
      end
   end

   // control and transaction registers next state
   always_comb begin
      ring_len_in = csr_write_enable ? csr_write_data : ring_len_ff;
      wp_in       = wp_ff;
      filled_in   = filled_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      wpe_in      = wpe_ff;
      fill_in     = fill_ff;
      dist_in     = dist_ff;
      smp_in      = smp_ff;
      frac_in     = frac_ff;
      hist_ok_in  = hist_ok_ff;

      if (cmd.load) begin
         len_in    = len_clamp;
         wpe_in    = (LEN_W'(wp_ff) < len_clamp) ? wp_ff : '0;
         fill_in   = (filled_ff < len_clamp) ? filled_ff : len_clamp;
         dist_in   = (req_payload.delay_distance < DIST_ONE) ? DIST_ONE
                                                             : req_payload.delay_distance;
         smp_in[0] = req_payload.left_write;
         smp_in[1] = req_payload.right_write;
      end

      if (cmd.position) begin
         hist_ok_in = hist_ok;
         frac_in    = pos_x[F-1:0];
      end

      if (cmd.clear_write) begin
         addr_in = addr_ff + ADDR_W'(1);
      end else if (cmd.position) begin
         addr_in = pos_x[F+ADDR_W-1:F];
      end else if (cmd.prev) begin
         addr_in = addr_dec;
      end else if (cmd.read) begin
         addr_in = addr_inc;
      end

      if (cmd.write) begin
         wp_in     = wp_next;
         filled_in = (fill_ff < len_ff) ? (fill_ff + LEN_W'(1)) : len_ff;
      end
   end

   // interpolation lanes next state
   always_comb begin
      y_in    = y_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      a2_in   = a2_ff;
      a1_in   = a1_ff;
      a0_in   = a0_ff;
      rsp_in  = rsp_ff;
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 4; k++) begin
            yx[c][k] = ACC_W'(y_ff[c][k]);
         end
         rnd[c]    = (prod_ff[c] + HALF) >>> F;
         half_v[c] = (acc_ff[c] + ACC_ONE) >>> 1;
         if (half_v[c] > SAT_MAX) begin
            sat_v[c] = SAT_MAX;
         end else if (half_v[c] < SAT_MIN) begin
            sat_v[c] = SAT_MIN;
         end else begin
            sat_v[c] = half_v[c];
         end
         out_v[c] = hist_ok_ff ? S'(sat_v[c]) : '0;

         // oldest read sits at index zero
         if (cmd.shift) begin
            y_in[c][0] = y_ff[c][1];
            y_in[c][1] = y_ff[c][2];
            y_in[c][2] = y_ff[c][3];
            y_in[c][3] = rd_ff[c];
         end

         // doubled catmull-rom coefficients
         if (cmd.coef) begin
            acc_in[c] = (yx[c][3] - yx[c][0]) + 3 * (yx[c][1] - yx[c][2]);
            a2_in[c]  = 2 * yx[c][0] - 5 * yx[c][1] + 4 * yx[c][2] - yx[c][3];
            a1_in[c]  = yx[c][2] - yx[c][0];
            a0_in[c]  = 2 * yx[c][1];
         end

         if (cmd.mul) begin
            prod_in[c] = PROD_W'(acc_ff[c]) * $signed(PROD_W'(frac_ff));
         end

         // rounded horner step, next coefficient moves up
         if (cmd.add) begin
            acc_in[c] = ACC_W'(rnd[c]) + a2_ff[c];
            a2_in[c]  = a1_ff[c];
            a1_in[c]  = a0_ff[c];
         end
      end
      if (cmd.out_load) begin
         rsp_in.left_read  = out_v[0];
         rsp_in.right_read = out_v[1];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_len_ff <= cidl_pkg::RING_LENGTH_RESET;
         wp_ff       <= '0;
         filled_ff   <= '0;
         addr_ff     <= '0;
      end else begin
         ring_len_ff <= ring_len_in;
         wp_ff       <= wp_in;
         filled_ff   <= filled_in;
         addr_ff     <= addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      wpe_ff     <= wpe_in;
      fill_ff    <= fill_in;
      dist_ff    <= dist_in;
      smp_ff     <= smp_in;
      frac_ff    <= frac_in;
      hist_ok_ff <= hist_ok_in;
      y_ff       <= y_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      a2_ff      <= a2_in;
      a1_ff      <= a1_in;
      a0_ff      <= a0_in;
      rsp_ff     <= rsp_in;
   end

   assign status.clear_last = (addr_ff == ADDR_W'(RING_DEPTH - 1));
   assign status.hist_ok    = hist_ok;
   assign rsp_payload       = rsp_ff;

endmodule

// ----- rtl/cidl_controller.sv -----
// ----------------------------------------------------------------------------
// cidl_controller
// Sequencer of the cubic interpolated delay line: clearing pass, ring reads,
// Horner steps, sample write and the result register handshake.
// ----------------------------------------------------------------------------
module cidl_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  cidl_pkg::cidl_status_type status,
   output cidl_pkg::cidl_cmd_type    cmd
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_POS   = 4'd2;
   localparam logic [3:0] ST_PREV  = 4'd3;
   localparam logic [3:0] ST_READ  = 4'd4;
   localparam logic [3:0] ST_LAST  = 4'd5;
   localparam logic [3:0] ST_COEF  = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_ADD   = 4'd8;
   localparam logic [3:0] ST_SKIP  = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;

   localparam logic [1:0] LAST_READ = 2'd3;
   localparam logic [1:0] LAST_STEP = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            cmd.position = 1'b1;
            state_in     = status.hist_ok ? ST_PREV : ST_SKIP;
         end
         ST_PREV: begin
            cmd.prev = 1'b1;
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read  = 1'b1;
            cmd.shift = (cnt_ff != '0);
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == LAST_READ) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            cmd.shift = 1'b1;
            state_in  = ST_COEF;
         end
         ST_COEF: begin
            cmd.coef  = 1'b1;
            cmd.write = 1'b1;
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            cnt_in  = cnt_ff + 2'd1;
            state_in = (cnt_ff == LAST_STEP) ? ST_FIN : ST_MUL;
         end
         ST_SKIP: begin
            cmd.write = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/cubic_interpolated_delay_line_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_interpolated_delay_line_unit
// Stereo fractional delay line with four-point cubic Hermite interpolation.
// ----------------------------------------------------------------------------
// After reset the unit zeroes both ring memories, one entry per cycle, and
// holds req_ready low until that pass is done; the csr port takes ring length
// writes at any time but should be written only while no transaction is in
// flight. A transaction whose delay distance has enough history holds
// req_ready low until it loads the result register, and req_ready is back in
// the cycle the result appears; the load waits while an earlier result is
// still not taken. The four neighbour reads go one per cycle through the
// single read port of each ring, and the Catmull-Rom polynomial is evaluated
// in three rounded multiply/add Horner steps. Without enough history the
// result is zero and the reads and Horner steps are skipped. The next request
// is taken while a finished result still waits on rsp_ready.
module cubic_interpolated_delay_line_unit #(
   parameter int RING_DEPTH = cidl_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cidl_pkg::cidl_req_type                req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cidl_pkg::cidl_rsp_type                rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [cidl_pkg::RING_LENGTH_BITS-1:0] csr_write_data
);

   cidl_pkg::cidl_cmd_type    cmd;
   cidl_pkg::cidl_status_type status;

   // sequencer
   cidl_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories and arithmetic
   cidl_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ----- test/cubic_interpolated_delay_line_checker.sv -----
// ----------------------------------------------------------------------------
// cubic_interpolated_delay_line_checker
// Watches the request, result and csr ports of the delay line, keeps its own
// copy of both rings, the write pointer, the fill level and the ring length,
// predicts every interpolated read and compares it with the result that
// comes out of the block.
// ----------------------------------------------------------------------------
module cubic_interpolated_delay_line_checker
   import cidl_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  cidl_req_type                req_payload,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  cidl_rsp_type                rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [RING_LENGTH_BITS-1:0] csr_write_data,
   output int                          mismatch_count,
   output int                          pending_count,
   output int                          checked_count
);

   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
   localparam longint UNIT_STEP = longint'(1) <<< FRACTION_BITS;
   localparam int     REPORT_LIMIT = 10;

   // shadow state of the delay line
   logic signed [SAMPLE_BITS-1:0] left_history  [RING_DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_history [RING_DEPTH];
   int unsigned                   head_index;
   int unsigned                   fill_level;
   logic [RING_LENGTH_BITS-1:0]   length_reg;

   cidl_rsp_type expected_reads[$];
   int           errors_seen;
   int           results_seen;

   // one horner step with round half up
   function automatic longint rounded_scale(input longint x);
      return (x + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
   endfunction

   // catmull-rom over four neighbors with doubled coefficients
   function automatic logic [SAMPLE_BITS-1:0] catmull_rom(input longint y0, input longint y1,
                                                          input longint y2, input longint y3,
                                                          input longint frac);
      longint a3, a2, a1, a0, acc;
      a3  = (y3 - y0) + 3 * (y1 - y2);
      a2  = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      a1  = y2 - y0;
      a0  = 2 * y1;
      acc = rounded_scale(a3 * frac) + a2;
      acc = rounded_scale(acc * frac) + a1;
      acc = rounded_scale(acc * frac) + a0;
      acc = (acc + 1) >>> 1;
      if (acc > SAMPLE_HI) begin
         acc = SAMPLE_HI;
      end else if (acc < SAMPLE_LO) begin
         acc = SAMPLE_LO;
      end
      return acc[SAMPLE_BITS-1:0];
   endfunction

   task automatic note_mismatch(input string what, input logic [SAMPLE_BITS-1:0] want,
                                input logic [SAMPLE_BITS-1:0] seen);
      errors_seen++;
      if (errors_seen <= REPORT_LIMIT) begin
         $display("mismatch on result %0d: %s expected %0d got %0d", results_seen, what,
                  $signed(want), $signed(seen));
      end
   endtask

   always @(posedge clock) begin : track
      int unsigned       ring_len, wp, filled, i1, n0, n2, n3;
      longint unsigned   read_distance;
      longint            pos, frac;
      cidl_rsp_type      exp_read;
      if (reset) begin
         for (int k = 0; k < RING_DEPTH; k++) begin
            left_history[k]  = '0;
            right_history[k] = '0;
         end
         head_index   = 0;
         fill_level   = 0;
         length_reg   = RING_LENGTH_RESET;
         errors_seen  = 0;
         results_seen = 0;
         expected_reads.delete();
      end else begin
         // ring length register
         if (csr_write_enable) begin
            length_reg = csr_write_data;
         end

         // result transaction against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_reads.size() == 0) begin
               errors_seen++;
               if (errors_seen <= REPORT_LIMIT) begin
                  $display("mismatch: result %0d with nothing waiting (left %0d right %0d)",
                           results_seen, rsp_payload.left_read, rsp_payload.right_read);
               end
            end else begin
               exp_read = expected_reads.pop_front();
               if (rsp_payload.left_read !== exp_read.left_read) begin
                  note_mismatch("left_read", exp_read.left_read, rsp_payload.left_read);
               end
               if (rsp_payload.right_read !== exp_read.right_read) begin
                  note_mismatch("right_read", exp_read.right_read, rsp_payload.right_read);
               end
            end
         end

         // request transaction: read before write, then advance
         if (req_valid && req_ready) begin
            ring_len = length_reg;
            if (ring_len < MIN_RING) begin
               ring_len = MIN_RING;
            end else if (ring_len > RING_DEPTH) begin
               ring_len = RING_DEPTH;
            end
            wp            = (head_index < ring_len) ? head_index : 0;
            filled        = (fill_level < ring_len) ? fill_level : ring_len;
            read_distance = req_payload.delay_distance;
            if (read_distance < UNIT_STEP) begin
               read_distance = UNIT_STEP;
            end
            exp_read = '0;
            if (read_distance + UNIT_STEP <= (longint'(filled) <<< FRACTION_BITS)) begin
               pos = (longint'(wp) <<< FRACTION_BITS) - longint'(read_distance);
               if (pos < 0) begin
                  pos = pos + (longint'(ring_len) <<< FRACTION_BITS);
               end
               i1   = int'((pos >>> FRACTION_BITS) % longint'(ring_len));
               frac = pos & (UNIT_STEP - 1);
               n0   = (i1 + ring_len - 1) % ring_len;
               n2   = (i1 + 1) % ring_len;
               n3   = (i1 + 2) % ring_len;
               exp_read.left_read  = catmull_rom(left_history[n0], left_history[i1],
                                                 left_history[n2], left_history[n3], frac);
               exp_read.right_read = catmull_rom(right_history[n0], right_history[i1],
                                                 right_history[n2], right_history[n3], frac);
            end
            expected_reads.push_back(exp_read);
            left_history[wp]  = req_payload.left_write;
            right_history[wp] = req_payload.right_write;
            wp++;
            if (wp >= ring_len) begin
               wp = 0;
            end
            head_index = wp;
            fill_level = (filled < ring_len) ? filled + 1 : ring_len;
         end
      end
      mismatch_count <= errors_seen;
      pending_count  <= expected_reads.size();
      checked_count  <= results_seen;
   end

endmodule

// ----- test/cubic_interpolated_delay_line_unit_tb.sv -----
// ----------------------------------------------------------------------------
// cubic_interpolated_delay_line_unit_tb
// Drives the stereo delay line with a directed set of edge cases at the reset
// ring length, then random transactions under a series of ring lengths that
// includes the clamped extremes, with random gaps on both channels. The
// checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module cubic_interpolated_delay_line_unit_tb;
   import cidl_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 200000;
   localparam int DRAIN_CYCLES    = 24;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int MAX_IDLE        = 8;
   localparam int DISTANCE_CAP    = 96;
   localparam int SETTING_COUNT   = 8;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   cidl_req_type                req_payload      = '0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   cidl_rsp_type                rsp_payload;
   logic                        csr_write_enable = 1'b0;
   logic [RING_LENGTH_BITS-1:0] csr_write_data   = '0;

   int          mismatch_count;
   int          pending_count;
   int          checked_count;
   bit          send_gaps_on  = 1'b1;
   bit          ready_gaps_on = 1'b1;
   int unsigned ready_hold    = 0;
   int unsigned idle_cycles   = 0;
   int          sent_count    = 0;

   cubic_interpolated_delay_line_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   cubic_interpolated_delay_line_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // result side: ready may drop for a random stall after each transaction
   always @(posedge clock) begin : ready_ctl
      int unsigned draw;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         draw = ready_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
         ready_hold <= draw;
         rsp_ready  <= (draw == 0);
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= (ready_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic cidl_req_type make_item(input logic [SAMPLE_BITS-1:0] left_sample,
                                              input logic [SAMPLE_BITS-1:0] right_sample,
                                              input logic [DISTANCE_BITS-1:0] distance);
      cidl_req_type item;
      item.left_write     = left_sample;
      item.right_write    = right_sample;
      item.delay_distance = distance;
      return item;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // mostly distances inside the history, some short or wild ones
   function automatic logic [DISTANCE_BITS-1:0] pick_distance(input int unsigned cap);
      logic [FRACTION_BITS-1:0] frac;
      logic [15:0]              whole;
      frac  = FRACTION_BITS'($urandom);
      whole = 16'($urandom_range(1, cap));
      case ($urandom_range(0, 9))
         0:       return {16'd0, frac};
         1:       return DISTANCE_BITS'($urandom);
         2:       return {whole, {FRACTION_BITS{1'b0}}};
         3:       return {whole, {FRACTION_BITS{1'b1}}};
         default: return {whole, frac};
      endcase
   endfunction

   task automatic send_item(input cidl_req_type item);
      int unsigned gap;
      gap = send_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_ring_length(input int unsigned value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= RING_LENGTH_BITS'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned ring_settings[SETTING_COUNT];
      int unsigned eff_len;
      int unsigned cap;
      ring_settings = '{8, 0, 37, 131071, 65536, 16, 9, 200};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty history, distance clamp, overshoot patterns, history edge
      send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 32'h0000_0000));
      send_item(make_item(SAMPLE_MIN, SAMPLE_MAX, 32'hFFFF_FFFF));
      send_item(make_item(SAMPLE_MIN, SAMPLE_MAX, 32'h0001_0000));
      send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 32'h0000_8000));
      send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 32'h0001_8000));
      send_item(make_item(SAMPLE_MIN, SAMPLE_MAX, 32'h0002_8000));
      send_item(make_item(SAMPLE_MIN, SAMPLE_MAX, 32'h0001_FFFF));
      send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 32'h0001_0001));
      send_item(make_item(SAMPLE_MAX, '0, 32'h0003_8000));
      send_item(make_item(SAMPLE_MIN, '1, 32'h0002_C000));
      send_item(make_item(SAMPLE_MIN, SAMPLE_MAX, 32'h0001_8000));
      send_item(make_item(24'h555555, 24'hAAAAAA, 32'h0004_FFFF));
      send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 32'h000D_0000));
      send_item(make_item(SAMPLE_MIN, SAMPLE_MAX, 32'h000D_0000));
      send_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 32'hFFFF_FFFF));
      send_item(make_item('0, '0, 32'h0000_FFFF));
      send_item(make_item(SAMPLE_MAX, SAMPLE_MAX, 32'h0002_8000));
      wait_drained();

      // random phases, one per ring length setting
      foreach (ring_settings[s]) begin
         write_ring_length(ring_settings[s]);
         eff_len = ring_settings[s];
         if (eff_len < MIN_RING) begin
            eff_len = MIN_RING;
         end else if (eff_len > RING_DEPTH_DEFAULT) begin
            eff_len = RING_DEPTH_DEFAULT;
         end
         cap = (eff_len + 2 < DISTANCE_CAP) ? eff_len + 2 : DISTANCE_CAP;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 16 == 0) begin
               send_gaps_on  = ($urandom_range(0, 3) != 0);
               ready_gaps_on = ($urandom_range(0, 3) != 0);
            end
            send_item(make_item(pick_sample(), pick_sample(), pick_distance(cap)));
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d transactions: directed cases at the reset ring length, then",
               sent_count);
      $display("random ones under %0d written ring lengths; %0d results compared, %0d mismatches",
               SETTING_COUNT, checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
